### rtl/bal_pkg.sv
// Shared constants, codes and types of the bounded array list engine.
package bal_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int KIND_W   = 4;
   localparam int POS_W    = 7;
   localparam int FIDX_W   = 6;
   localparam int LEN_W    = 7;

   typedef enum logic [KIND_W-1:0] {
      KIND_INS_END   = 4'd0,
      KIND_INS_FRONT = 4'd1,
      KIND_INS_POS   = 4'd2,
      KIND_INS_SORT  = 4'd3,
      KIND_RM_FRONT  = 4'd4,
      KIND_RM_END    = 4'd5,
      KIND_RM_POS    = 4'd6,
      KIND_RM_VAL    = 4'd7,
      KIND_FIND      = 4'd8,
      KIND_CLEAR     = 4'd9
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_SCAN_END,
      ST_INS_RD,
      ST_INS_WR,
      ST_PUT,
      ST_OLD_RD,
      ST_OLD_SUB,
      ST_RM_RD,
      ST_RM_WR,
      ST_RM_FIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              we;
      logic [IDX_W-1:0]  waddr;
      logic [DATA_W-1:0] wdata;
      logic [IDX_W-1:0]  raddr;
   } mem_req_type;

   typedef struct packed {
      logic                     ok;
      logic                     found;
      logic [FIDX_W-1:0]        found_index;
      logic [LEN_W-1:0]         length;
      logic signed [DATA_W-1:0] total;
   } result_type;

endpackage

### rtl/bal_store.sv
// Entry store: one write port and one registered read port.
module bal_store (
   input  logic                       clock,
   input  bal_pkg::mem_req_type       mem_req,
   output logic [bal_pkg::DATA_W-1:0] rdata
);
   import bal_pkg::*;

   logic [DATA_W-1:0] mem [CAPACITY];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
      rdata_ff <= mem[mem_req.raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/bal_unit.sv
// Shared compare and accumulate unit.
module bal_unit (
   input  logic [bal_pkg::DATA_W-1:0] value,
   input  logic [bal_pkg::DATA_W-1:0] rdata,
   input  logic [bal_pkg::DATA_W-1:0] acc,
   input  logic                       sub,
   output logic                       lt,
   output logic                       eq,
   output logic [bal_pkg::DATA_W-1:0] acc_out
);
   import bal_pkg::*;

   assign lt      = $signed(rdata) < $signed(value);
   assign eq      = (rdata == value);
   assign acc_out = sub ? (acc - rdata) : (acc + value);

endmodule

### rtl/bal_seq.sv
// Sequencer: scan, shift and bookkeeping for one list operation at a time.
module bal_seq (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_accept,
   input  logic [bal_pkg::KIND_W-1:0] req_kind,
   input  logic [bal_pkg::DATA_W-1:0] req_value,
   input  logic [bal_pkg::POS_W-1:0]  req_position,
   input  logic                       out_free,
   output logic                       ready,
   output logic                       done,
   output bal_pkg::result_type        result,
   output bal_pkg::mem_req_type       mem_req,
   input  logic [bal_pkg::DATA_W-1:0] rdata,
   output logic [bal_pkg::DATA_W-1:0] unit_value,
   output logic [bal_pkg::DATA_W-1:0] unit_acc,
   output logic                       unit_sub,
   input  logic                       unit_lt,
   input  logic                       unit_eq,
   input  logic [bal_pkg::DATA_W-1:0] unit_acc_out
);
   import bal_pkg::*;

   state_type         state_ff, state_in;
   kind_type          kind_ff, kind_in;
   logic [DATA_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  tgt_ff, tgt_in;
   logic              hit_ff, hit_in;
   logic              ok_ff, ok_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [DATA_W-1:0] sum_ff, sum_in;

   logic             room;
   logic             some;
   logic [CNT_W-1:0] pos;
   kind_type         req_code;

   assign room     = count_ff < CNT_W'(CAPACITY);
   assign some     = count_ff != '0;
   assign pos      = CNT_W'(req_position);
   assign req_code = kind_type'(req_kind);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         sum_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      value_ff <= value_in;
      idx_ff   <= idx_in;
      tgt_ff   <= tgt_in;
      hit_ff   <= hit_in;
      ok_ff    <= ok_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_code)
                  KIND_INS_END:   state_in = room ? ST_PUT : ST_DONE;
                  KIND_INS_FRONT: state_in = room ? (some ? ST_INS_RD : ST_PUT) : ST_DONE;
                  KIND_INS_POS: begin
                     if (room && pos <= count_ff) begin
                        state_in = (count_ff > pos) ? ST_INS_RD : ST_PUT;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  KIND_INS_SORT:  state_in = room ? (some ? ST_SCAN_RD : ST_SCAN_END) : ST_DONE;
                  KIND_RM_FRONT,
                  KIND_RM_END:    state_in = some ? ST_OLD_RD : ST_DONE;
                  KIND_RM_POS:    state_in = (pos < count_ff) ? ST_OLD_RD : ST_DONE;
                  KIND_RM_VAL,
                  KIND_FIND:      state_in = some ? ST_SCAN_RD : ST_SCAN_END;
                  default:        state_in = ST_DONE;
               endcase
            end
         end
         ST_SCAN_RD:  state_in = ST_SCAN_CMP;
         ST_SCAN_CMP: state_in = (idx_ff + CNT_W'(1) < count_ff) ? ST_SCAN_RD : ST_SCAN_END;
         ST_SCAN_END: begin
            unique case (kind_ff)
               KIND_INS_SORT: state_in = (count_ff > tgt_ff) ? ST_INS_RD : ST_PUT;
               KIND_RM_VAL:   state_in = hit_ff ? ST_OLD_RD : ST_DONE;
               default:       state_in = ST_DONE;
            endcase
         end
         ST_INS_RD:  state_in = ST_INS_WR;
         ST_INS_WR:  state_in = (idx_ff - CNT_W'(1) > tgt_ff) ? ST_INS_RD : ST_PUT;
         ST_PUT:     state_in = ST_DONE;
         ST_OLD_RD:  state_in = ST_OLD_SUB;
         ST_OLD_SUB: state_in = (tgt_ff + CNT_W'(1) < count_ff) ? ST_RM_RD : ST_RM_FIN;
         ST_RM_RD:   state_in = ST_RM_WR;
         ST_RM_WR:   state_in = (idx_ff + CNT_W'(2) < count_ff) ? ST_RM_RD : ST_RM_FIN;
         ST_RM_FIN:  state_in = ST_DONE;
         ST_DONE:    state_in = out_free ? ST_IDLE : ST_DONE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // datapath next values
   always_comb begin
      kind_in  = kind_ff;
      value_in = value_ff;
      idx_in   = idx_ff;
      tgt_in   = tgt_ff;
      hit_in   = hit_ff;
      ok_in    = ok_ff;
      count_in = count_ff;
      sum_in   = sum_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               kind_in  = req_code;
               value_in = req_value;
               ok_in    = 1'b0;
               hit_in   = 1'b0;
               idx_in   = count_ff;
               tgt_in   = '0;
               case (req_code)
                  KIND_INS_END: tgt_in = count_ff;
                  KIND_INS_POS,
                  KIND_RM_POS:  tgt_in = pos;
                  KIND_RM_END:  tgt_in = count_ff - CNT_W'(1);
                  KIND_INS_SORT,
                  KIND_RM_VAL,
                  KIND_FIND: begin
                     idx_in = '0;
                     ok_in  = (req_code == KIND_FIND);
                  end
                  KIND_CLEAR: begin
                     count_in = '0;
                     sum_in   = '0;
                     ok_in    = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN_CMP: begin
            idx_in = idx_ff + CNT_W'(1);
            case (kind_ff)
               KIND_INS_SORT: begin
                  if (unit_lt) begin
                     tgt_in = idx_ff + CNT_W'(1);
                  end
               end
               KIND_RM_VAL: begin
                  if (unit_eq) begin
                     tgt_in = idx_ff;
                     hit_in = 1'b1;
                  end
               end
               KIND_FIND: begin
                  if (unit_eq && !hit_ff) begin
                     tgt_in = idx_ff;
                     hit_in = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         ST_SCAN_END: idx_in = count_ff;
         ST_INS_WR:   idx_in = idx_ff - CNT_W'(1);
         ST_PUT: begin
            count_in = count_ff + CNT_W'(1);
            sum_in   = unit_acc_out;
            ok_in    = 1'b1;
         end
         ST_OLD_SUB: begin
            sum_in = unit_acc_out;
            idx_in = tgt_ff;
         end
         ST_RM_WR: idx_in = idx_ff + CNT_W'(1);
         ST_RM_FIN: begin
            count_in = count_ff - CNT_W'(1);
            ok_in    = 1'b1;
         end
         default: ;
      endcase
   end

   // outputs
   always_comb begin
      mem_req       = '0;
      ready         = 1'b0;
      done          = 1'b0;
      unit_sub      = 1'b0;
      unit_value    = value_ff;
      unit_acc      = sum_ff;
      unique case (state_ff)
         ST_IDLE:    ready = 1'b1;
         ST_SCAN_RD: mem_req.raddr = IDX_W'(idx_ff);
         ST_INS_RD:  mem_req.raddr = IDX_W'(idx_ff - CNT_W'(1));
         ST_INS_WR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = IDX_W'(idx_ff);
            mem_req.wdata = rdata;
         end
         ST_PUT: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = IDX_W'(tgt_ff);
            mem_req.wdata = value_ff;
         end
         ST_OLD_RD:  mem_req.raddr = IDX_W'(tgt_ff);
         ST_OLD_SUB: unit_sub = 1'b1;
         ST_RM_RD:   mem_req.raddr = IDX_W'(idx_ff + CNT_W'(1));
         ST_RM_WR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = IDX_W'(idx_ff);
            mem_req.wdata = rdata;
         end
         ST_DONE:    done = 1'b1;
         default: ;
      endcase
      result.ok          = ok_ff;
      result.found       = (kind_ff == KIND_FIND) && hit_ff;
      result.found_index = ((kind_ff == KIND_FIND) && hit_ff) ? FIDX_W'(tgt_ff) : '0;
      result.length      = LEN_W'(count_ff);
      result.total       = sum_ff;
   end

endmodule

### rtl/bounded_array_list_engine.sv
// Top level of the bounded array list engine.
// Keeps an ordered list of up to 64 signed 32-bit entries in a single-port-read,
// single-port-write store and answers one operation per item with ok, find
// status, length and the wrapping sum. One item is worked at a time: a scan
// reads then compares each entry examined, and each shifted entry is read and
// then written through the one store port. Clear and rejected operations are
// the shortest items; sorted insert and remove by value on a long list are the
// longest. The result sits in an output register, so the next item is taken
// while a result still waits on rsp_stall.
module bounded_array_list_engine (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bal_pkg::KIND_W-1:0]        req_kind,
   input  logic signed [bal_pkg::DATA_W-1:0] req_value,
   input  logic [bal_pkg::POS_W-1:0]         req_position,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_ok,
   output logic                              rsp_found,
   output logic [bal_pkg::FIDX_W-1:0]        rsp_found_index,
   output logic [bal_pkg::LEN_W-1:0]         rsp_length,
   output logic signed [bal_pkg::DATA_W-1:0] rsp_total
);
   import bal_pkg::*;

   mem_req_type       mem_req;
   logic [DATA_W-1:0] rdata;
   logic [DATA_W-1:0] unit_value;
   logic [DATA_W-1:0] unit_acc;
   logic [DATA_W-1:0] unit_acc_out;
   logic              unit_sub;
   logic              unit_lt;
   logic              unit_eq;
   logic              ready;
   logic              done;
   logic              out_free;
   logic              req_accept;
   result_type        result;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_data_ff, rsp_data_in;

   assign req_stall  = !ready;
   assign req_accept = req_valid && ready;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   bal_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (rdata)
   );

   bal_unit u_unit (
      .value   (unit_value),
      .rdata   (rdata),
      .acc     (unit_acc),
      .sub     (unit_sub),
      .lt      (unit_lt),
      .eq      (unit_eq),
      .acc_out (unit_acc_out)
   );

   bal_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_accept   (req_accept),
      .req_kind     (req_kind),
      .req_value    (req_value),
      .req_position (req_position),
      .out_free     (out_free),
      .ready        (ready),
      .done         (done),
      .result       (result),
      .mem_req      (mem_req),
      .rdata        (rdata),
      .unit_value   (unit_value),
      .unit_acc     (unit_acc),
      .unit_sub     (unit_sub),
      .unit_lt      (unit_lt),
      .unit_eq      (unit_eq),
      .unit_acc_out (unit_acc_out)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = done;
         if (done) begin
            rsp_data_in = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_data_ff.ok;
   assign rsp_found       = rsp_data_ff.found;
   assign rsp_found_index = rsp_data_ff.found_index;
   assign rsp_length      = rsp_data_ff.length;
   assign rsp_total       = rsp_data_ff.total;

endmodule
